>>> src/rtsa_pkg.sv
// Shared types, widths and constants for the ratiometric temperature sensor averager.
// Used by every module in src; no dependencies of its own.

package rtsa_pkg;

  // Parameter defaults
  localparam int ADC_BITS_DEF    = 12;
  localparam int MAX_SAMPLES_DEF = 64;

  // Field and register widths
  localparam int SUM_W      = 29;
  localparam int TEMP_W     = 25;
  localparam int AVG_W      = 23;
  localparam int SPR_W      = 7;
  localparam int V25_W      = 22;
  localparam int SLOPE_W    = 15;
  localparam int T25_W      = 15;
  localparam int CFG_W      = 22;
  localparam int CFG_ADDR_W = 2;
  localparam int OUT_DATA_W = 72;

  // Datapath widths
  localparam int MAG_W   = 56;               // |100*(v25*1024 - avg*1e6)| < 2^56
  localparam int DVD_W   = MAG_W;            // divider dividend / quotient
  localparam int DVR_W   = SLOPE_W + 10;     // widest divisor: slope*1024
  localparam int STEP_W  = $clog2(DVD_W + 1);
  localparam int PV_W    = 39;               // v25*102400
  localparam int TSUM_W  = 27;               // clamped quotient plus t25
  localparam int QCLMP_W = 25;

  // Arithmetic constants (1.20 V reference, volts times 1024, times 10)
  localparam logic [13:0] VREF_Q10X10 = 14'd12288;
  localparam logic [16:0] V25_SCALE   = 17'd102400;     // 1024 * 100
  localparam logic [26:0] SENSE_SCALE = 27'd100000000;  // 1e6 * 100
  localparam logic signed [TSUM_W-1:0] TEMP_MAX = 27'sd12000000;
  localparam logic signed [TSUM_W-1:0] TEMP_MIN = -27'sd12000000;

  // Register reset values
  localparam logic [SPR_W-1:0]          SPR_RST   = 7'd10;
  localparam logic [V25_W-1:0]          V25_RST   = 22'd1430000;
  localparam logic [SLOPE_W-1:0]        SLOPE_RST = 15'd4300;
  localparam logic signed [T25_W-1:0]   T25_RST   = 15'sd2500;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SAMPLES = 2'd0,
    CFG_V25     = 2'd1,
    CFG_SLOPE   = 2'd2,
    CFG_T25     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_PAIR,
    DIV_AVG,
    DIV_TEMP
  } div_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAIR_GO,
    ST_PAIR_WAIT,
    ST_ACC,
    ST_CHECK,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_AVG_SAVE,
    ST_PRODUCT,
    ST_DIFF,
    ST_TEMP_GO,
    ST_TEMP_WAIT,
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic    take_in;
    logic    div_start;
    div_op_t div_op;
    logic    acc;
    logic    save_avg;
    logic    mult;
    logic    sub;
    logic    fin;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic window_full;
    logic out_free;
  } sts_t;

endpackage

>>> src/ratiometric_temp_sensor_averager.sv
// Throughput: one pair at a time; the next pair is taken only once the last is done. Each pair
//   goes through the bit-serial divider that forms supply and sense voltages in two lanes together.
// Window close: the pair closing a window adds the averages and the 56-step temperature division,
//   plus any wait for the output register to free up.
// Reset: rst_n is synchronous, active low; it restores register defaults and clears the sums,
//   the count, the output valid flag and the controller. Uses rtsa_pkg, rtsa_ctrl, rtsa_datapath.

module ratiometric_temp_sensor_averager #(
  parameter int ADC_BITS    = rtsa_pkg::ADC_BITS_DEF,
  parameter int MAX_SAMPLES = rtsa_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((2*ADC_BITS+7)/8)*8-1:0]      in_tdata,   // sensor_reading, reference_reading
  // Result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [rtsa_pkg::OUT_DATA_W-1:0]      out_tdata,  // temperature_centi, supply_q10,
                                                           // sense_q10, zero pad
  // Configuration port
  input  logic                                 cfg_we,
  input  logic [rtsa_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [rtsa_pkg::CFG_W-1:0]           cfg_wdata
);

  rtsa_pkg::cmd_t cmd;
  rtsa_pkg::sts_t sts;

  // Controller: walks each transaction through divide, accumulate and, at the
  // end of a window, average, scale and temperature division.
  rtsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: holds the config, the window sums and the result register.
  // Upper pad bits of in_tdata are dropped here.
  rtsa_datapath #(
    .ADC_BITS    (ADC_BITS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .sensor_reading    (in_tdata[ADC_BITS-1:0]),
    .reference_reading (in_tdata[2*ADC_BITS-1:ADC_BITS]),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .out_tready        (out_tready),
    .out_tvalid        (out_tvalid),
    .out_tdata         (out_tdata)
  );

endmodule

>>> src/rtsa_div.sv
// Iterative restoring divider, one quotient bit per cycle, two lanes sharing a divisor.
// Depends on rtsa_pkg.

module rtsa_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [rtsa_pkg::DVD_W-1:0]        dvd_a,   // left-aligned dividend
  input  logic [rtsa_pkg::DVD_W-1:0]        dvd_b,
  input  logic [rtsa_pkg::DVR_W-1:0]        dvr,
  input  logic [rtsa_pkg::STEP_W-1:0]       steps,
  output logic                              busy,
  output logic [rtsa_pkg::DVD_W-1:0]        quot_a,
  output logic [rtsa_pkg::DVD_W-1:0]        quot_b
);

  localparam int DW = rtsa_pkg::DVD_W;
  localparam int RW = rtsa_pkg::DVR_W;

  logic [DW-1:0]                  a_r, b_r;
  logic [RW-1:0]                  ra_r, rb_r, dvr_r;
  logic [rtsa_pkg::STEP_W-1:0]    cnt_r;
  logic                           busy_r;
  logic [RW+1:0]                  trial_a, trial_b;

  // Shift in the next dividend bit and try the subtract; the top bit is the borrow.
  assign trial_a = {1'b0, ra_r, a_r[DW-1]} - {2'b00, dvr_r};
  assign trial_b = {1'b0, rb_r, b_r[DW-1]} - {2'b00, dvr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == rtsa_pkg::STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= dvd_a;
      b_r   <= dvd_b;
      ra_r  <= '0;
      rb_r  <= '0;
      dvr_r <= dvr;
    end else if (busy_r) begin
      a_r <= {a_r[DW-2:0], ~trial_a[RW+1]};
      b_r <= {b_r[DW-2:0], ~trial_b[RW+1]};
      ra_r <= trial_a[RW+1] ? {ra_r[RW-2:0], a_r[DW-1]} : trial_a[RW-1:0];
      rb_r <= trial_b[RW+1] ? {rb_r[RW-2:0], b_r[DW-1]} : trial_b[RW-1:0];
    end
  end

  assign busy   = busy_r;
  assign quot_a = a_r;
  assign quot_b = b_r;

endmodule

>>> src/rtsa_datapath.sv
// Datapath: config registers, running sums, products, shared divider and result register.
// Depends on rtsa_pkg and rtsa_div.

module rtsa_datapath #(
  parameter int ADC_BITS    = rtsa_pkg::ADC_BITS_DEF,
  parameter int MAX_SAMPLES = rtsa_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rtsa_pkg::cmd_t                      cmd,
  output rtsa_pkg::sts_t                      sts,
  input  logic [ADC_BITS-1:0]                 sensor_reading,
  input  logic [ADC_BITS-1:0]                 reference_reading,
  input  logic                                cfg_we,
  input  logic [rtsa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [rtsa_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [rtsa_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int PAIR_W = ADC_BITS + 14;
  localparam int DIV10_W = ADC_BITS + 4;
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int DW = rtsa_pkg::DVD_W;
  localparam int MW = rtsa_pkg::MAG_W;
  localparam int SW = rtsa_pkg::SUM_W;
  localparam logic [PAIR_W-1:0] PAIR_BASE = PAIR_W'(rtsa_pkg::VREF_Q10X10) << ADC_BITS;

  // Configuration registers
  logic [rtsa_pkg::SPR_W-1:0]          spr_r;
  logic [rtsa_pkg::V25_W-1:0]          v25_r;
  logic [rtsa_pkg::SLOPE_W-1:0]        slope_r;
  logic signed [rtsa_pkg::T25_W-1:0]   t25_r;

  // Working registers
  logic [PAIR_W-1:0]                   pnum_r;
  logic [DIV10_W-1:0]                  div10_r;
  logic [SW-1:0]                       supply_sum_r, sense_sum_r;
  logic [CNT_W-1:0]                    cnt_r;
  logic [SW-1:0]                       avg_supply_r, avg_sense_r;
  logic [rtsa_pkg::PV_W-1:0]           prod_v_r;
  logic [MW-1:0]                       prod_s_r;
  logic [MW:0]                         diff_r;
  logic [rtsa_pkg::TEMP_W-1:0]         temp_r;
  logic                                out_valid_r;
  logic [rtsa_pkg::OUT_DATA_W-1:0]     out_data_r;

  logic [ADC_BITS-1:0]                 ref_eff;
  logic [CNT_W-1:0]                    n_eff;
  logic [rtsa_pkg::SLOPE_W-1:0]        slope_eff;
  logic [DW-1:0]                       dvd_a, dvd_b, quot_a, quot_b;
  logic [rtsa_pkg::DVR_W-1:0]          dvr;
  logic [rtsa_pkg::STEP_W-1:0]         steps;
  logic                                div_busy;
  logic [MW-1:0]                       mag;
  logic [rtsa_pkg::QCLMP_W-1:0]        qclamp;
  logic signed [rtsa_pkg::TSUM_W-1:0]  qsigned, tsum;
  logic [rtsa_pkg::TEMP_W-1:0]         temp_nxt;

  assign ref_eff   = (reference_reading == '0) ? ADC_BITS'(1) : reference_reading;
  assign slope_eff = (slope_r == '0) ? rtsa_pkg::SLOPE_W'(1) : slope_r;

  always_comb begin
    if (spr_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(spr_r) > MAX_SAMPLES) begin
      n_eff = CNT_W'(MAX_SAMPLES);
    end else begin
      n_eff = CNT_W'(spr_r);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r   <= rtsa_pkg::SPR_RST;
      v25_r   <= rtsa_pkg::V25_RST;
      slope_r <= rtsa_pkg::SLOPE_RST;
      t25_r   <= rtsa_pkg::T25_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rtsa_pkg::CFG_SAMPLES: spr_r   <= cfg_wdata[rtsa_pkg::SPR_W-1:0];
        rtsa_pkg::CFG_V25:     v25_r   <= cfg_wdata[rtsa_pkg::V25_W-1:0];
        rtsa_pkg::CFG_SLOPE:   slope_r <= cfg_wdata[rtsa_pkg::SLOPE_W-1:0];
        rtsa_pkg::CFG_T25:     t25_r   <= $signed(cfg_wdata[rtsa_pkg::T25_W-1:0]);
        default: ;
      endcase
    end
  end

  // Divider operand select; every dividend is left-aligned to its bit count
  assign mag = diff_r[MW] ? MW'(-diff_r) : diff_r[MW-1:0];

  always_comb begin
    case (cmd.div_op)
      rtsa_pkg::DIV_PAIR: begin
        dvd_a = DW'(PAIR_BASE) << (DW - PAIR_W);
        dvd_b = DW'(pnum_r) << (DW - PAIR_W);
        dvr   = rtsa_pkg::DVR_W'(div10_r);
        steps = rtsa_pkg::STEP_W'(PAIR_W);
      end
      rtsa_pkg::DIV_AVG: begin
        dvd_a = DW'(supply_sum_r) << (DW - SW);
        dvd_b = DW'(sense_sum_r) << (DW - SW);
        dvr   = rtsa_pkg::DVR_W'(n_eff);
        steps = rtsa_pkg::STEP_W'(SW);
      end
      rtsa_pkg::DIV_TEMP: begin
        dvd_a = DW'(mag);
        dvd_b = '0;
        dvr   = {slope_eff, 10'b0};
        steps = rtsa_pkg::STEP_W'(MW);
      end
      default: begin
        dvd_a = '0;
        dvd_b = '0;
        dvr   = rtsa_pkg::DVR_W'(1);
        steps = rtsa_pkg::STEP_W'(1);
      end
    endcase
  end

  rtsa_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .dvd_a  (dvd_a),
    .dvd_b  (dvd_b),
    .dvr    (dvr),
    .steps  (steps),
    .busy   (div_busy),
    .quot_a (quot_a),
    .quot_b (quot_b)
  );

  // Temperature: clamp the quotient magnitude, apply sign, add t25, saturate
  assign qclamp  = (|quot_a[DW-1:rtsa_pkg::QCLMP_W]) ? '1 : quot_a[rtsa_pkg::QCLMP_W-1:0];
  assign qsigned = diff_r[MW] ? -$signed({2'b00, qclamp}) : $signed({2'b00, qclamp});
  assign tsum    = qsigned + rtsa_pkg::TSUM_W'(t25_r);

  always_comb begin
    if (tsum > rtsa_pkg::TEMP_MAX) begin
      temp_nxt = rtsa_pkg::TEMP_W'(rtsa_pkg::TEMP_MAX);
    end else if (tsum < rtsa_pkg::TEMP_MIN) begin
      temp_nxt = rtsa_pkg::TEMP_W'(rtsa_pkg::TEMP_MIN);
    end else begin
      temp_nxt = tsum[rtsa_pkg::TEMP_W-1:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      pnum_r  <= sensor_reading * rtsa_pkg::VREF_Q10X10;
      div10_r <= ref_eff * 4'd10;
    end
    if (cmd.save_avg) begin
      avg_supply_r <= quot_a[SW-1:0];
      avg_sense_r  <= quot_b[SW-1:0];
    end
    if (cmd.mult) begin
      prod_v_r <= v25_r * rtsa_pkg::V25_SCALE;
      prod_s_r <= avg_sense_r * rtsa_pkg::SENSE_SCALE;
    end
    if (cmd.sub) begin
      diff_r <= {1'b0, MW'(prod_v_r)} - {1'b0, prod_s_r};
    end
    if (cmd.fin) begin
      temp_r <= temp_nxt;
    end
    if (cmd.out_load) begin
      out_data_r <= {1'b0, avg_sense_r[rtsa_pkg::AVG_W-1:0],
                     avg_supply_r[rtsa_pkg::AVG_W-1:0], temp_r};
    end
  end

  // Window state: sums wrap at their width, clear once the window averages are saved
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_sum_r <= '0;
      sense_sum_r  <= '0;
      cnt_r        <= '0;
    end else if (cmd.acc) begin
      supply_sum_r <= supply_sum_r + quot_a[SW-1:0];
      sense_sum_r  <= sense_sum_r + quot_b[SW-1:0];
      cnt_r        <= cnt_r + 1'b1;
    end else if (cmd.save_avg) begin
      supply_sum_r <= '0;
      sense_sum_r  <= '0;
      cnt_r        <= '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.div_busy    = div_busy;
  assign sts.window_full = (cnt_r >= n_eff);
  assign sts.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= MAX_SAMPLES)
    else $error("pair count beyond sample limit");

endmodule

>>> src/rtsa_ctrl.sv
// Controller state machine: sequences pair division, accumulation and the result computation.
// Depends on rtsa_pkg.

module rtsa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  rtsa_pkg::sts_t  sts,
  output rtsa_pkg::cmd_t  cmd
);

  rtsa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtsa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtsa_pkg::ST_IDLE:      if (in_tvalid) state_nxt = rtsa_pkg::ST_PAIR_GO;
      rtsa_pkg::ST_PAIR_GO:   state_nxt = rtsa_pkg::ST_PAIR_WAIT;
      rtsa_pkg::ST_PAIR_WAIT: if (!sts.div_busy) state_nxt = rtsa_pkg::ST_ACC;
      rtsa_pkg::ST_ACC:       state_nxt = rtsa_pkg::ST_CHECK;
      rtsa_pkg::ST_CHECK: begin
        state_nxt = sts.window_full ? rtsa_pkg::ST_AVG_GO : rtsa_pkg::ST_IDLE;
      end
      rtsa_pkg::ST_AVG_GO:    state_nxt = rtsa_pkg::ST_AVG_WAIT;
      rtsa_pkg::ST_AVG_WAIT:  if (!sts.div_busy) state_nxt = rtsa_pkg::ST_AVG_SAVE;
      rtsa_pkg::ST_AVG_SAVE:  state_nxt = rtsa_pkg::ST_PRODUCT;
      rtsa_pkg::ST_PRODUCT:   state_nxt = rtsa_pkg::ST_DIFF;
      rtsa_pkg::ST_DIFF:      state_nxt = rtsa_pkg::ST_TEMP_GO;
      rtsa_pkg::ST_TEMP_GO:   state_nxt = rtsa_pkg::ST_TEMP_WAIT;
      rtsa_pkg::ST_TEMP_WAIT: if (!sts.div_busy) state_nxt = rtsa_pkg::ST_FINISH;
      rtsa_pkg::ST_FINISH:    state_nxt = rtsa_pkg::ST_EMIT;
      rtsa_pkg::ST_EMIT:      if (sts.out_free) state_nxt = rtsa_pkg::ST_IDLE;
      default:                state_nxt = rtsa_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd        = '0;
    cmd.div_op = rtsa_pkg::DIV_PAIR;
    in_tready  = 1'b0;
    unique case (state_r)
      rtsa_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.take_in = in_tvalid;
      end
      rtsa_pkg::ST_PAIR_GO:  cmd.div_start = 1'b1;
      rtsa_pkg::ST_ACC:      cmd.acc = 1'b1;
      rtsa_pkg::ST_AVG_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = rtsa_pkg::DIV_AVG;
      end
      rtsa_pkg::ST_AVG_SAVE: cmd.save_avg = 1'b1;
      rtsa_pkg::ST_PRODUCT:  cmd.mult = 1'b1;
      rtsa_pkg::ST_DIFF:     cmd.sub = 1'b1;
      rtsa_pkg::ST_TEMP_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = rtsa_pkg::DIV_TEMP;
      end
      rtsa_pkg::ST_FINISH:   cmd.fin = 1'b1;
      rtsa_pkg::ST_EMIT:     cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result overwritten before taken");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second pair taken while one is in work");

endmodule
